// ----- hdl/free_list_heap_allocator_unit_defines.svh -----
// Assertion macros for the free-list heap allocator.
// Used by the checker bound to the top level.
`ifndef FREE_LIST_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FREE_LIST_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FLHA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FLHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hdl/flha_pkg.sv -----
// Package for the free-list heap allocator: state codes and constants.
// No dependencies.
package flha_pkg;
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoFit   = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StUnknown = 2'd3;
  localparam logic OpAlloc = 1'b0;
  localparam logic CfgPolicy = 1'b0;
  localparam logic CfgHeap   = 1'b1;
  localparam logic [20:0] HeapMin   = 21'd16;
  localparam logic [20:0] HeapMax   = 21'd1048576;
  localparam logic [20:0] HeapReset = 21'd65536;
  localparam logic [3:0]  MinAlign  = 4'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_ASLOT, S_ASCAN, S_APAD, S_ACHK, S_ACOMMIT, S_ASHIFT,
    S_FFIND, S_FPOS, S_FDECIDE, S_FSHL, S_FSHR, S_FCOMMIT, S_OUT
  } state_e;
endpackage

// ----- hdl/flha_pad.sv -----
// Header padding unit: aligned distance from a block start that fits a header.
// Uses flha_pkg.
module flha_pad import flha_pkg::*; #(
  parameter int HeaderBytes = 16
) (
  input  logic [19:0] base_i,
  input  logic [3:0]  lg_i,
  output logic [21:0] pad_o
);
  logic [21:0] a, p, need, k;
  always_comb begin
    a = 22'd1 << lg_i;
    p = a - ({2'b0, base_i} & (a - 22'd1));
    need = 22'(HeaderBytes) - p;
    k = (need + a - 22'd1) >> lg_i;
    pad_o = p;
    if (p < 22'(HeaderBytes)) pad_o = p + (k << lg_i);
  end
endmodule

// ----- hdl/free_list_heap_allocator_unit.sv -----
// Free-list heap allocator: one request at a time, one result per request.
// An allocate scans allocation slots, then the free table one entry at a time
// (padding computed, then fit compared, in two states per entry), then shifts
// entries when a block is consumed. A free scans slots, finds the insert position,
// and shifts entries one a cycle when it merges with both neighbours or inserts a
// new entry. The result is held until out_ready_i takes it. Writing heap_size
// reinitializes the free table and the allocation slots.
module free_list_heap_allocator_unit import flha_pkg::*; #(
  parameter int MaxFreeBlocks  = 16,
  parameter int MaxAllocations = 16,
  parameter int NodeBytes      = 16,
  parameter int HeaderBytes    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [20:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [20:0] alloc_size_i,
  input  logic [3:0]  align_log2_i,
  input  logic [19:0] data_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [19:0] result_offset_o,
  output logic [20:0] block_bytes_o,
  output logic [20:0] used_bytes_o,
  output logic [20:0] peak_bytes_o
);
  localparam int FW = $clog2(MaxFreeBlocks);
  localparam int CW = $clog2(MaxFreeBlocks + 1);
  localparam int AW = (MaxAllocations > 1) ? $clog2(MaxAllocations) : 1;
  localparam int SW = $clog2(MaxAllocations + 1);

  state_e state_q, state_d;
  logic policy_q;
  logic [19:0] fstart_q [MaxFreeBlocks];
  logic [20:0] flen_q [MaxFreeBlocks];
  logic [CW-1:0] fcnt_q;
  logic [MaxAllocations-1:0] avalid_q;
  logic [19:0] adata_q [MaxAllocations];
  logic [19:0] astart_q [MaxAllocations];
  logic [20:0] alen_q [MaxAllocations];
  logic [20:0] used_q, peak_q;

  logic [20:0] size_q;
  logic [3:0] lg_q;
  logic [19:0] off_q;
  logic [SW-1:0] si_q;
  logic [CW-1:0] fi_q, found_q, pos_q, sh_q;
  logic found_v_q;
  logic [21:0] pad_q, fpad_q, bdiff_q;
  logic [19:0] bs_q;
  logic [20:0] bl_q;
  logic mprev_q, mnext_q;
  logic [1:0] st_q;
  logic [19:0] ro_q;
  logic [20:0] bb_q;

  logic [FW-1:0] fidx;
  logic [21:0] pad_w;
  assign fidx = fi_q[FW-1:0];
  flha_pad #(.HeaderBytes(HeaderBytes)) u_pad (
    .base_i(fstart_q[fidx]), .lg_i(lg_q), .pad_o(pad_w));

  logic [AW-1:0] sidx;
  assign sidx = si_q[AW-1:0];
  logic [22:0] need_w;
  assign need_w = {2'b0, size_q} + {1'b0, pad_q};
  logic fits_w;
  assign fits_w = {2'b0, flen_q[fidx]} >= need_w;
  logic [22:0] diff_w;
  assign diff_w = {2'b0, flen_q[fidx]} - need_w;

  logic [FW-1:0] fnd, pidx, pm1;
  assign fnd = found_q[FW-1:0];
  assign pidx = pos_q[FW-1:0];
  assign pm1 = pidx - FW'(1);
  logic [22:0] rest_w;
  assign rest_w = {2'b0, flen_q[fnd]} - {2'b0, size_q} - {1'b0, fpad_q};

  logic cfg_fire, in_fire;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;
  assign in_fire = in_valid_i && in_ready_o;

  function automatic logic [22:0] need_fp(logic [20:0] s, logic [21:0] p);
    return {2'b0, s} + {1'b0, p};
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_fire) state_d = (op_i == OpAlloc) ? S_ASLOT : S_FFIND;
      S_ASLOT: begin
        if (si_q == SW'(MaxAllocations)) state_d = S_OUT;
        else if (!avalid_q[sidx]) state_d = S_ASCAN;
      end
      S_ASCAN:  state_d = (fi_q >= fcnt_q) ? S_ACHK : S_APAD;
      S_APAD:   state_d = S_ASCAN;
      S_ACHK:   state_d = found_v_q ? S_ACOMMIT : S_OUT;
      S_ACOMMIT: state_d = (rest_w >= 23'(NodeBytes)) ? S_OUT : S_ASHIFT;
      S_ASHIFT: if (sh_q + CW'(1) >= fcnt_q) state_d = S_OUT;
      S_FFIND: begin
        if (si_q == SW'(MaxAllocations)) state_d = S_OUT;
        else if (avalid_q[sidx] && adata_q[sidx] == off_q) state_d = S_FPOS;
      end
      S_FPOS: if (fi_q >= fcnt_q || fstart_q[fidx] >= bs_q) state_d = S_FDECIDE;
      S_FDECIDE: state_d = S_FCOMMIT;
      S_FCOMMIT: begin
        if (!mprev_q && !mnext_q && fcnt_q >= CW'(MaxFreeBlocks)) state_d = S_OUT;
        else if (mprev_q && mnext_q) state_d = S_FSHL;
        else if (!mprev_q && !mnext_q) state_d = S_FSHR;
        else state_d = S_OUT;
      end
      S_FSHL: if (sh_q + CW'(1) >= fcnt_q) state_d = S_OUT;
      S_FSHR: if (sh_q <= pos_q) state_d = S_OUT;
      S_OUT:  if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = (state_q == S_OUT);
  assign status_o = st_q;
  assign result_offset_o = ro_q;
  assign block_bytes_o = bb_q;
  assign used_bytes_o = used_q;
  assign peak_bytes_o = peak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      policy_q <= 1'b0;
      fcnt_q <= CW'(1);
      avalid_q <= '0;
      used_q <= '0;
      peak_q <= '0;
      for (int i = 0; i < MaxFreeBlocks; i++) begin
        fstart_q[i] <= '0;
        flen_q[i] <= (i == 0) ? HeapReset : '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_fire) begin
        if (cfg_index_i == CfgPolicy) begin
          policy_q <= cfg_data_i[0];
        end else begin
          fstart_q[0] <= '0;
          flen_q[0] <= (cfg_data_i < HeapMin) ? HeapMin :
                       (cfg_data_i > HeapMax) ? HeapMax : cfg_data_i;
          fcnt_q <= CW'(1);
          avalid_q <= '0;
          used_q <= '0;
          peak_q <= '0;
        end
      end
      case (state_q)
        S_IDLE: if (in_fire) begin
          size_q <= (alloc_size_i < 21'(NodeBytes)) ? 21'(NodeBytes) : alloc_size_i;
          lg_q <= (align_log2_i < MinAlign) ? MinAlign : align_log2_i;
          off_q <= data_offset_i;
          si_q <= '0;
          fi_q <= '0;
          found_v_q <= 1'b0;
          st_q <= StOk; ro_q <= '0; bb_q <= '0;
        end
        S_ASLOT: begin
          if (si_q == SW'(MaxAllocations)) st_q <= StFull;
          else if (avalid_q[sidx]) si_q <= si_q + SW'(1);
        end
        S_ASCAN: if (fi_q < fcnt_q) begin
          pad_q <= pad_w;
        end
        S_APAD: begin
          if (fits_w && (!found_v_q || {1'b0, bdiff_q} > diff_w)) begin
            found_q <= fi_q; found_v_q <= 1'b1;
            bdiff_q <= diff_w[21:0]; fpad_q <= pad_q;
          end
          fi_q <= (fits_w && !policy_q) ? fcnt_q : fi_q + CW'(1);
        end
        S_ACHK: if (!found_v_q) st_q <= StNoFit;
        S_ACOMMIT: begin
          astart_q[sidx] <= fstart_q[fnd];
          adata_q[sidx] <= fstart_q[fnd] + fpad_q[19:0];
          ro_q <= fstart_q[fnd] + fpad_q[19:0];
          avalid_q[sidx] <= 1'b1;
          st_q <= StOk;
          if (rest_w >= 23'(NodeBytes)) begin
            alen_q[sidx] <= 21'(need_fp(size_q, fpad_q));
            bb_q <= 21'(need_fp(size_q, fpad_q));
            fstart_q[fnd] <= fstart_q[fnd] + 20'(need_fp(size_q, fpad_q));
            flen_q[fnd] <= rest_w[20:0];
            used_q <= used_q + 21'(need_fp(size_q, fpad_q));
            if (used_q + 21'(need_fp(size_q, fpad_q)) > peak_q)
              peak_q <= used_q + 21'(need_fp(size_q, fpad_q));
          end else begin
            alen_q[sidx] <= flen_q[fnd];
            bb_q <= flen_q[fnd];
            used_q <= used_q + flen_q[fnd];
            if (used_q + flen_q[fnd] > peak_q) peak_q <= used_q + flen_q[fnd];
            sh_q <= found_q;
          end
        end
        S_ASHIFT: begin
          if (sh_q + CW'(1) < fcnt_q) begin
            fstart_q[sh_q[FW-1:0]] <= fstart_q[FW'(sh_q + CW'(1))];
            flen_q[sh_q[FW-1:0]] <= flen_q[FW'(sh_q + CW'(1))];
            sh_q <= sh_q + CW'(1);
          end else fcnt_q <= fcnt_q - CW'(1);
        end
        S_FFIND: begin
          if (si_q == SW'(MaxAllocations)) st_q <= StUnknown;
          else if (avalid_q[sidx] && adata_q[sidx] == off_q) begin
            bs_q <= astart_q[sidx];
            bl_q <= alen_q[sidx];
          end else si_q <= si_q + SW'(1);
        end
        S_FPOS: begin
          if (fi_q >= fcnt_q || fstart_q[fidx] >= bs_q) pos_q <= fi_q;
          else fi_q <= fi_q + CW'(1);
        end
        S_FDECIDE: begin
          mnext_q <= (pos_q < fcnt_q) &&
                     ({1'b0, bs_q} + bl_q == {1'b0, fstart_q[pidx]});
          mprev_q <= (pos_q != '0) &&
                     ({1'b0, fstart_q[pm1]} + flen_q[pm1] == {1'b0, bs_q});
        end
        S_FCOMMIT: begin
          if (!mprev_q && !mnext_q && fcnt_q >= CW'(MaxFreeBlocks)) begin
            st_q <= StFull; ro_q <= '0; bb_q <= '0;
          end else begin
            st_q <= StOk; ro_q <= '0; bb_q <= bl_q;
            avalid_q[sidx] <= 1'b0;
            used_q <= (used_q >= bl_q) ? used_q - bl_q : '0;
            if (mprev_q && mnext_q) begin
              flen_q[pm1] <= flen_q[pm1] + bl_q + flen_q[pidx];
              sh_q <= pos_q;
            end else if (mprev_q) begin
              flen_q[pm1] <= flen_q[pm1] + bl_q;
            end else if (mnext_q) begin
              fstart_q[pidx] <= bs_q;
              flen_q[pidx] <= flen_q[pidx] + bl_q;
            end else begin
              sh_q <= fcnt_q;
            end
          end
        end
        S_FSHL: begin
          if (sh_q + CW'(1) < fcnt_q) begin
            fstart_q[sh_q[FW-1:0]] <= fstart_q[FW'(sh_q + CW'(1))];
            flen_q[sh_q[FW-1:0]] <= flen_q[FW'(sh_q + CW'(1))];
            sh_q <= sh_q + CW'(1);
          end else fcnt_q <= fcnt_q - CW'(1);
        end
        S_FSHR: begin
          if (sh_q > pos_q) begin
            fstart_q[sh_q[FW-1:0]] <= fstart_q[FW'(sh_q - CW'(1))];
            flen_q[sh_q[FW-1:0]] <= flen_q[FW'(sh_q - CW'(1))];
            sh_q <= sh_q - CW'(1);
          end else begin
            fstart_q[pidx] <= bs_q;
            flen_q[pidx] <= bl_q;
            fcnt_q <= fcnt_q + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- hdl/flha_checker.sv -----
// Port-level checker for the heap allocator, bound to the top level.
// Uses the assertion macros header and flha_pkg.
`include "free_list_heap_allocator_unit_defines.svh"
module flha_checker import flha_pkg::*; (
  input logic clk_i, rst_ni, in_valid_i, in_ready_o, out_valid_o, out_ready_i,
  input logic cfg_ready_o,
  input logic [1:0] status_o,
  input logic [20:0] block_bytes_o, used_bytes_o, peak_bytes_o,
  input logic [19:0] result_offset_o
);
  `FLHA_ASSERT_IMP(a_peak, clk_i, rst_ni, out_valid_o, peak_bytes_o >= used_bytes_o)
  `FLHA_ASSERT_IMP(a_fail0, clk_i, rst_ni, out_valid_o && status_o != StOk, block_bytes_o == '0)
  `FLHA_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `FLHA_ASSERT_IMP(a_excl, clk_i, rst_ni, out_valid_o, !in_ready_o && !cfg_ready_o)
endmodule

bind free_list_heap_allocator_unit flha_checker u_flha_checker (.*);

// ----- sim/tb_free_list_heap_allocator_unit.sv -----
// Self-checking bench for free_list_heap_allocator_unit: random and directed
// allocate/free traffic checked against an in-bench allocator predictor.
// Depends on flha_pkg and the allocator RTL.
module tb_free_list_heap_allocator_unit import flha_pkg::*;;

  localparam int NFree = 16;
  localparam int NSlot = 16;
  localparam int NodeB = 16;
  localparam int HdrB = 16;
  localparam int Limit = 2000000;

  typedef struct packed {
    logic        op;
    logic [20:0] size;
    logic [3:0]  lg;
    logic [19:0] off;
  } req_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [19:0] off;
    logic [20:0] bytes;
    logic [20:0] used;
    logic [20:0] peak;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [20:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic op_i = 1'b0;
  logic [20:0] alloc_size_i = '0;
  logic [3:0] align_log2_i = '0;
  logic [19:0] data_offset_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic [19:0] result_offset_o;
  logic [20:0] block_bytes_o, used_bytes_o, peak_bytes_o;

  free_list_heap_allocator_unit dut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state
  logic        pol;
  logic [20:0] hsize;
  logic [63:0] fs [NFree];
  logic [63:0] fl [NFree];
  int          fcnt;
  logic        av [NSlot];
  logic [19:0] ad [NSlot];
  logic [63:0] abs_ [NSlot];
  logic [63:0] abl [NSlot];
  logic [63:0] used, peak;

  req_t pending[$];
  rsp_t expected_rsp[$];
  logic [19:0] live_offs[$];
  int mism = 0, errs = 0, n_in = 0, n_out = 0, cyc = 0;

  function automatic void heap_reinit();
    for (int i = 0; i < NFree; i++) begin fs[i] = 0; fl[i] = 0; end
    for (int i = 0; i < NSlot; i++) av[i] = 0;
    fs[0] = 0; fl[0] = hsize; fcnt = 1; used = 0; peak = 0;
  endfunction

  function automatic logic [63:0] hdr_pad(logic [63:0] base, int lg);
    logic [63:0] a, p, need;
    a = 64'd1 << lg;
    p = a - (base & (a - 1));
    if (p < HdrB) begin
      need = HdrB - p;
      p += a * ((need + a - 1) / a);
    end
    return p;
  endfunction

  function automatic rsp_t predict_alloc(req_t r);
    rsp_t o;
    logic [63:0] sz, bd, pad, p, nd, rq, rest, blen;
    int lg, slot, found;
    o = '0;
    sz = r.size; if (sz < NodeB) sz = NodeB;
    lg = r.lg; if (lg < 3) lg = 3;
    slot = NSlot; found = NFree; bd = 0; pad = 0;
    for (int i = NSlot - 1; i >= 0; i--) if (!av[i]) slot = i;
    if (slot == NSlot) begin
      o.st = StFull; o.used = 21'(used); o.peak = 21'(peak); return o;
    end
    for (int i = 0; i < fcnt; i++) begin
      p = hdr_pad(fs[i], lg); nd = sz + p;
      if (fl[i] >= nd) begin
        if (found == NFree || fl[i] - nd < bd) begin
          found = i; bd = fl[i] - nd; pad = p;
        end
        if (!pol) break;
      end
    end
    if (found == NFree) begin
      o.st = StNoFit; o.used = 21'(used); o.peak = 21'(peak); return o;
    end
    rq = sz + pad; rest = fl[found] - rq;
    abs_[slot] = fs[found];
    ad[slot] = 20'(fs[found] + pad);
    if (rest >= NodeB) begin
      blen = rq; fs[found] += rq; fl[found] = rest;
    end else begin
      blen = fl[found];
      for (int i = found; i + 1 < fcnt; i++) begin fs[i] = fs[i+1]; fl[i] = fl[i+1]; end
      fcnt--;
    end
    abl[slot] = blen; av[slot] = 1;
    used += blen; if (used > peak) peak = used;
    o.st = StOk; o.off = ad[slot]; o.bytes = 21'(blen); o.used = 21'(used);
    o.peak = 21'(peak);
    return o;
  endfunction

  function automatic rsp_t predict_free(req_t r);
    rsp_t o;
    int slot, pos, n;
    logic [63:0] bs, bl;
    logic mn, mp;
    o = '0; slot = NSlot;
    for (int i = NSlot - 1; i >= 0; i--) if (av[i] && ad[i] == r.off) slot = i;
    if (slot == NSlot) begin
      o.st = StUnknown; o.used = 21'(used); o.peak = 21'(peak); return o;
    end
    bs = abs_[slot]; bl = abl[slot]; n = fcnt; pos = n;
    for (int i = n - 1; i >= 0; i--) if (fs[i] >= bs) pos = i;
    mn = pos < n && bs + bl == fs[pos];
    mp = pos > 0 && fs[pos-1] + fl[pos-1] == bs;
    if (!mn && !mp && n >= NFree) begin
      o.st = StFull; o.used = 21'(used); o.peak = 21'(peak); return o;
    end
    if (mp && mn) begin
      fl[pos-1] += bl + fl[pos];
      for (int i = pos; i + 1 < n; i++) begin fs[i] = fs[i+1]; fl[i] = fl[i+1]; end
      n--;
    end else if (mp) fl[pos-1] += bl;
    else if (mn) begin fs[pos] = bs; fl[pos] += bl; end
    else begin
      for (int i = n; i > pos; i--) begin fs[i] = fs[i-1]; fl[i] = fl[i-1]; end
      fs[pos] = bs; fl[pos] = bl; n++;
    end
    fcnt = n; av[slot] = 0;
    used = (used >= bl) ? used - bl : 0;
    o.st = StOk; o.bytes = 21'(bl); o.used = 21'(used); o.peak = 21'(peak);
    return o;
  endfunction

  // driver
  logic drv_idle_en = 1'b1;
  logic hold_off = 1'b0;
  logic quiet = 1'b0;
  logic in_ready_seen = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || (in_valid_i && in_ready_seen)) begin
        if (pending.size() > 0 && !quiet &&
            !(drv_idle_en && $urandom_range(99) < 25)) begin
          req_t r;
          r = pending.pop_front();
          op_i <= r.op; alloc_size_i <= r.size; align_log2_i <= r.lg;
          data_offset_i <= r.off; in_valid_i <= 1'b1;
        end else in_valid_i <= 1'b0;
      end
      out_ready_i <= !hold_off && !(drv_idle_en && $urandom_range(99) < 25);
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    in_ready_seen <= 1'b0;
    if (rst_ni && in_valid_i && in_ready_o) begin
      req_t r;
      r = '{op_i, alloc_size_i, align_log2_i, data_offset_i};
      in_ready_seen <= 1'b1;
      n_in <= n_in + 1;
      expected_rsp.push_back(r.op == OpAlloc ? predict_alloc(r) : predict_free(r));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      rsp_t a, e;
      a = '{status_o, result_offset_o, block_bytes_o, used_bytes_o, peak_bytes_o};
      n_out <= n_out + 1;
      if (expected_rsp.size() == 0) begin
        errs <= errs + 1;
        if (mism < 10) $display("unexpected result %h", a);
        mism <= mism + 1;
      end else begin
        e = expected_rsp.pop_front();
        if (a !== e) begin
          errs <= errs + 1;
          if (mism < 10)
            $display("mismatch exp st=%0d off=%h b=%0d u=%0d p=%0d %s",
              e.st, e.off, e.bytes, e.used, e.peak,
              $sformatf("got st=%0d off=%h b=%0d u=%0d p=%0d",
                a.st, a.off, a.bytes, a.used, a.peak));
          mism <= mism + 1;
        end
      end
    end
    if (cyc > Limit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic cfg_write(logic idx, logic [20:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx; cfg_data_i <= val; cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CfgPolicy) pol = val[0];
    else begin
      hsize = val < HeapMin ? HeapMin : (val > HeapMax ? HeapMax : val);
      heap_reinit();
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid_i || expected_rsp.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic req_t mk_alloc(logic [20:0] s, logic [3:0] l);
    return '{OpAlloc, s, l, 20'($urandom)};
  endfunction

  function automatic req_t mk_free(logic [19:0] o);
    return '{~OpAlloc, 21'($urandom), 4'($urandom), o};
  endfunction

  // push a random request: a free of a tracked live offset, a raw random request, or an allocate
  task automatic push_rand(int small_sizes);
    req_t r;
    int k;
    if (live_offs.size() > 0 && $urandom_range(99) < 45) begin
      k = $urandom_range(live_offs.size() - 1);
      r = mk_free(live_offs[k]);
      live_offs.delete(k);
    end else if ($urandom_range(99) < 8) begin
      r = '{1'($urandom), 21'($urandom), 4'($urandom), 20'($urandom)};
    end else begin
      r = mk_alloc(small_sizes ? 21'($urandom_range(600)) : 21'($urandom), 4'($urandom));
    end
    pending.push_back(r);
  endtask

  // collect granted offsets from the result side for later frees
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i && status_o == StOk && block_bytes_o != 0 &&
        result_offset_o != 0 && live_offs.size() < 64)
      live_offs.push_back(result_offset_o);

  initial begin
    pol = 1'b0; hsize = HeapReset; heap_reinit();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    // directed
    pending.push_back(mk_alloc(21'd0, 4'd0));
    pending.push_back(mk_alloc(21'd16, 4'd3));
    pending.push_back(mk_alloc(21'd100, 4'd12));
    pending.push_back(mk_alloc(21'd24, 4'd15));
    pending.push_back(mk_alloc(21'h1FFFFF, 4'd5));
    pending.push_back(mk_free(20'd16));
    pending.push_back(mk_free(20'hFFFFF));
    pending.push_back(mk_free(20'd4096));
    for (int i = 0; i < 14; i++) pending.push_back(mk_alloc(21'd40, 4'd4));
    drain();
    cfg_write(CfgPolicy, 21'd1);
    cfg_write(CfgHeap, 21'd0);
    pending.push_back(mk_alloc(21'd0, 4'd3));
    pending.push_back(mk_alloc(21'd0, 4'd3));
    drain();
    cfg_write(CfgHeap, 21'h1FFFFF);
    pending.push_back(mk_alloc(21'd1048576, 4'd3));
    pending.push_back(mk_alloc(21'd1048560, 4'd3));
    pending.push_back(mk_free(20'd16));
    drain();
    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      live_offs.delete();
      cfg_write(CfgPolicy, 21'($urandom_range(1)));
      cfg_write(CfgHeap, ph == 0 ? HeapMax : (ph == 1 ? 21'd2048 : 21'($urandom_range(16, 8192))));
      drv_idle_en = (ph != 2);
      for (int i = 0; i < 210; i++) begin
        push_rand(ph != 0);
        // receiver stalls in its own process while requests keep coming
        if (ph == 3 && i == 100) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (400) @(posedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
        if (i % 20 == 19) begin
          while (pending.size() > 2) @(posedge clk_i);
        end
      end
      drain();
    end
    $display("covered %0d requests, %0d results, both policies, heap sizes 16 to max", n_in, n_out);
    if (errs == 0 && expected_rsp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/flha_pkg.sv
hdl/flha_pad.sv
hdl/free_list_heap_allocator_unit.sv
hdl/flha_checker.sv
sim/tb_free_list_heap_allocator_unit.sv
